>>> sv/i2cbe_pkg.sv
// ----------------------------------------------------------------------------
// i2cbe_pkg
// Types, codes and reset constants shared by the I2C master bit engine.
// ----------------------------------------------------------------------------
`default_nettype none

package i2cbe_pkg;

  // Command codes carried by a request
  typedef enum logic [2:0] {
    OP_NONE  = 3'd0,
    OP_START = 3'd1,
    OP_STOP  = 3'd2,
    OP_WRITE = 3'd3,
    OP_READ  = 3'd4,
    OP_ACK   = 3'd5,
    OP_NACK  = 3'd6,
    OP_CHECK = 3'd7
  } opcode_t;

  // Configuration register indexes
  localparam logic [1:0] REG_SHORT_WAIT  = 2'd0;
  localparam logic [1:0] REG_LONG_WAIT   = 2'd1;
  localparam logic [1:0] REG_ACK_TIMEOUT = 2'd2;

  localparam logic [7:0] SHORT_WAIT_RST  = 8'd2;
  localparam logic [7:0] LONG_WAIT_RST   = 8'd4;
  localparam logic [9:0] ACK_TIMEOUT_RST = 10'd250;

  // Bus phases
  typedef enum logic [3:0] {
    PH_IDLE = 4'd0,
    PH_ST_A = 4'd1,
    PH_ST_B = 4'd2,
    PH_ST_C = 4'd3,
    PH_ST_D = 4'd4,
    PH_SP_A = 4'd5,
    PH_SP_B = 4'd6,
    PH_SP_C = 4'd7,
    PH_WR_H = 4'd8,
    PH_WR_L = 4'd9,
    PH_RD_H = 4'd10,
    PH_RD_L = 4'd11,
    PH_AK_H = 4'd12,
    PH_CK_A = 4'd13,
    PH_CK_B = 4'd14,
    PH_CK_P = 4'd15
  } phase_t;

  typedef struct packed {
    logic [2:0] opcode;
    logic [7:0] write_data;
    logic       sda_in;
  } in_item_t;

  typedef struct packed {
    logic       scl_level;
    logic       sda_level;
    logic       sda_enable;
    logic       busy_res;
    logic       done_res;
    logic [7:0] read_data;
    logic       ack_error;
  } out_item_t;

  typedef struct packed {
    logic [7:0] short_wait;
    logic [7:0] long_wait;
    logic [9:0] ack_timeout;
  } cfg_t;

  // Wait counter load: a zero setting counts as one tick
  function automatic logic [7:0] load_wait(input logic [7:0] w);
    load_wait = (w == 8'd0) ? 8'd0 : w - 8'd1;
  endfunction

endpackage

`default_nettype wire

>>> sv/i2cbe_cfg.sv
// ----------------------------------------------------------------------------
// i2cbe_cfg
// Timing configuration registers: short wait, long wait, acknowledge timeout.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbe_cfg (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           wr_en,
  input  wire logic [1:0]     wr_index,
  input  wire logic [9:0]     wr_data,
  output i2cbe_pkg::cfg_t     cfg
);
  import i2cbe_pkg::*;

  // Write the addressed register; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.short_wait  <= SHORT_WAIT_RST;
      cfg.long_wait   <= LONG_WAIT_RST;
      cfg.ack_timeout <= ACK_TIMEOUT_RST;
    end else if (wr_en) begin
      unique case (wr_index)
        REG_SHORT_WAIT:  cfg.short_wait  <= wr_data[7:0];
        REG_LONG_WAIT:   cfg.long_wait   <= wr_data[7:0];
        REG_ACK_TIMEOUT: cfg.ack_timeout <= wr_data;
        default: ;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> sv/i2cbe_step.sv
// ----------------------------------------------------------------------------
// i2cbe_step
// Bus phase sequencer: advances one tick per request and forms the result.
// ----------------------------------------------------------------------------
`default_nettype none

module i2cbe_step (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 fire,
  input  wire i2cbe_pkg::in_item_t  item,
  input  wire i2cbe_pkg::cfg_t      cfg,
  output i2cbe_pkg::out_item_t      result
);
  import i2cbe_pkg::*;

  phase_t      phase, phase_next;
  logic [7:0]  wait_count, wait_count_next;
  logic [3:0]  bit_count, bit_count_next;
  logic [7:0]  shift_byte, shift_byte_next;
  logic [9:0]  poll_count, poll_count_next;
  logic        pin_scl, pin_scl_next;
  logic        pin_sda, pin_sda_next;
  logic        pin_en, pin_en_next;
  logic [7:0]  read_reg, read_reg_next;
  logic        err_flag, err_flag_next;
  logic        done;
  logic        ent;
  phase_t      tgt;
  logic        do_poll;
  logic [10:0] poll_inc;

  // Hold state between ticks
  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_IDLE;
      wait_count <= '0;
      bit_count  <= '0;
      shift_byte <= '0;
      poll_count <= '0;
      pin_scl    <= 1'b1;
      pin_sda    <= 1'b1;
      pin_en     <= 1'b0;
      read_reg   <= '0;
      err_flag   <= 1'b0;
    end else if (fire) begin
      phase      <= phase_next;
      wait_count <= wait_count_next;
      bit_count  <= bit_count_next;
      shift_byte <= shift_byte_next;
      poll_count <= poll_count_next;
      pin_scl    <= pin_scl_next;
      pin_sda    <= pin_sda_next;
      pin_en     <= pin_en_next;
      read_reg   <= read_reg_next;
      err_flag   <= err_flag_next;
    end
  end

  // Next state for one tick
  always_comb begin
    phase_next      = phase;
    wait_count_next = wait_count;
    bit_count_next  = bit_count;
    shift_byte_next = shift_byte;
    poll_count_next = poll_count;
    pin_scl_next    = pin_scl;
    pin_sda_next    = pin_sda;
    pin_en_next     = pin_en;
    read_reg_next   = read_reg;
    err_flag_next   = err_flag;
    done            = 1'b0;
    ent             = 1'b0;
    tgt             = PH_IDLE;
    do_poll         = 1'b0;
    poll_inc        = {1'b0, poll_count} + 11'd1;

    // Accept a command, poll, count down or advance the phase
    unique case (phase)
      PH_IDLE: begin
        if (item.opcode != OP_NONE) begin
          bit_count_next = '0;
          ent = 1'b1;
          unique case (opcode_t'(item.opcode))
            OP_START: tgt = PH_ST_A;
            OP_STOP:  tgt = PH_SP_A;
            OP_WRITE: begin
              pin_en_next     = 1'b1;
              shift_byte_next = item.write_data;
              tgt             = PH_WR_H;
            end
            OP_READ: begin
              pin_en_next     = 1'b0;
              pin_scl_next    = 1'b0;
              shift_byte_next = '0;
              tgt             = PH_RD_H;
            end
            OP_ACK: begin
              pin_sda_next = 1'b0;
              pin_en_next  = 1'b1;
              tgt          = PH_AK_H;
            end
            OP_NACK: begin
              pin_sda_next = 1'b1;
              tgt          = PH_AK_H;
            end
            OP_CHECK: begin
              err_flag_next   = 1'b0;
              poll_count_next = '0;
              tgt             = PH_CK_A;
            end
            default: ent = 1'b0;
          endcase
        end
      end
      PH_CK_P: do_poll = 1'b1;
      default: begin
        if (wait_count != 8'd0) begin
          wait_count_next = wait_count - 8'd1;
        end else begin
          ent = 1'b1;
          unique case (phase)
            PH_ST_A: tgt = PH_ST_B;
            PH_ST_B: tgt = PH_ST_C;
            PH_ST_C: tgt = PH_ST_D;
            PH_SP_A: tgt = PH_SP_B;
            PH_SP_B: tgt = PH_SP_C;
            PH_WR_H: tgt = PH_WR_L;
            PH_WR_L: begin
              bit_count_next = bit_count + 4'd1;
              if (bit_count_next[3]) begin
                ent = 1'b0;
                phase_next = PH_IDLE;
                done = 1'b1;
              end else begin
                tgt = PH_WR_H;
              end
            end
            PH_RD_H: begin
              shift_byte_next = {shift_byte[6:0], item.sda_in};
              tgt = PH_RD_L;
            end
            PH_RD_L: begin
              bit_count_next = bit_count + 4'd1;
              if (bit_count_next[3]) begin
                ent = 1'b0;
                read_reg_next = shift_byte;
                phase_next = PH_IDLE;
                done = 1'b1;
              end else begin
                tgt = PH_RD_H;
              end
            end
            PH_AK_H: begin
              ent = 1'b0;
              pin_scl_next = 1'b0;
              phase_next = PH_IDLE;
              done = 1'b1;
            end
            PH_CK_A: tgt = PH_CK_B;
            PH_CK_B: begin
              ent = 1'b0;
              phase_next = PH_CK_P;
              wait_count_next = '0;
              do_poll = 1'b1;
            end
            default: begin
              ent = 1'b0;
              phase_next = PH_IDLE;
              done = 1'b1;
            end
          endcase
        end
      end
    endcase

    // Poll SDA for the acknowledge; on timeout run a stop
    if (do_poll) begin
      if (!item.sda_in) begin
        pin_scl_next = 1'b0;
        phase_next   = PH_IDLE;
        done         = 1'b1;
      end else if (poll_inc > {1'b0, cfg.ack_timeout}) begin
        err_flag_next = 1'b1;
        ent = 1'b1;
        tgt = PH_SP_A;
      end else begin
        poll_count_next = poll_inc[9:0];
      end
    end

    // Apply the pin levels and wait of the phase entered
    if (ent) begin
      phase_next = tgt;
      unique case (tgt)
        PH_ST_A: begin
          pin_sda_next = 1'b1;
          pin_en_next  = 1'b1;
          wait_count_next = load_wait(cfg.long_wait);
        end
        PH_ST_B: begin
          pin_scl_next = 1'b1;
          wait_count_next = load_wait(cfg.long_wait);
        end
        PH_ST_C: begin
          pin_sda_next = 1'b0;
          wait_count_next = load_wait(cfg.short_wait);
        end
        PH_ST_D: begin
          pin_scl_next = 1'b0;
          wait_count_next = load_wait(cfg.long_wait);
        end
        PH_SP_A: begin
          pin_scl_next = 1'b0;
          pin_sda_next = 1'b0;
          pin_en_next  = 1'b1;
          wait_count_next = load_wait(cfg.long_wait);
        end
        PH_SP_B: begin
          pin_scl_next = 1'b1;
          wait_count_next = load_wait(cfg.long_wait);
        end
        PH_SP_C: begin
          pin_sda_next = 1'b1;
          wait_count_next = load_wait(cfg.short_wait);
        end
        PH_WR_H: begin
          pin_sda_next    = shift_byte_next[7];
          shift_byte_next = {shift_byte_next[6:0], 1'b0};
          pin_scl_next    = 1'b1;
          wait_count_next = load_wait(cfg.short_wait);
        end
        PH_WR_L, PH_RD_L: begin
          pin_scl_next = 1'b0;
          wait_count_next = load_wait(cfg.short_wait);
        end
        PH_RD_H, PH_AK_H: begin
          pin_scl_next = 1'b1;
          wait_count_next = load_wait(cfg.short_wait);
        end
        PH_CK_A: begin
          pin_scl_next = 1'b0;
          pin_sda_next = 1'b1;
          pin_en_next  = 1'b0;
          wait_count_next = load_wait(cfg.long_wait);
        end
        PH_CK_B: begin
          pin_scl_next = 1'b1;
          wait_count_next = load_wait(cfg.long_wait);
        end
        default: wait_count_next = '0;
      endcase
    end

    // Form the result as the pins stand after this tick
    result.scl_level  = pin_scl_next;
    result.sda_level  = pin_sda_next;
    result.sda_enable = pin_en_next;
    result.busy_res   = (phase_next != PH_IDLE);
    result.done_res   = done;
    result.read_data  = read_reg_next;
    result.ack_error  = err_flag_next;
  end

endmodule

`default_nettype wire

>>> sv/i2c_master_bit_engine.sv
// A request taken into the input register is processed by the sequencer into the
// result register. Throughput: one request per cycle unless the result stalls;
// the phase sequencer advances one tick per request. A stalled result holds the
// request in the input register until the held request can be processed.
// Reset: synchronous; sequencer idle, SCL high, SDA released, timing registers
// back to short wait 2, long wait 4, acknowledge timeout 250.
// ----------------------------------------------------------------------------
// i2c_master_bit_engine
// Tick-driven I2C master bit engine: input register, phase sequencer, result
// register, plus the timing configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module i2c_master_bit_engine (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire i2cbe_pkg::in_item_t in_item,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output i2cbe_pkg::out_item_t     out_item,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [1:0]          cfg_index,
  input  wire logic [9:0]          cfg_data
);
  import i2cbe_pkg::*;

  logic      in_full;
  in_item_t  in_q;
  logic      fire;
  cfg_t      cfg;
  out_item_t step_result;

  assign cfg_ready = 1'b1;

  // Process the held request when the result register can take its result
  assign fire     = in_full && (!out_valid || out_ready);
  assign in_ready = !in_full || fire;

  // Hold the incoming request
  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (in_ready) begin
      in_full <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_q <= in_item;
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      out_item <= step_result;
    end
  end

  i2cbe_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  i2cbe_step u_step (
    .clk    (clk),
    .rst    (rst),
    .fire   (fire),
    .item   (in_q),
    .cfg    (cfg),
    .result (step_result)
  );

endmodule

`default_nettype wire
